// ===== design/dmd_pkg.sv =====
package dmd_pkg;

  localparam int Depth  = 32768;
  localparam int AddrW  = 15;
  localparam int DimDef = 32;
  localparam int PixW   = 10;   // enough for a dimension of up to 1024
  localparam int CfgAW  = 3;
  localparam int CfgDW  = 32;
  localparam int QuoW   = 25;   // quotient bits below the saturation point
  localparam int NumW   = 54;   // rounded dividend width
  localparam int DenW   = 49;   // denominator width

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncProc = 1'b1;

  typedef enum logic [CfgAW-1:0] {
    REG_HOMOG = 3'd0,
    REG_GAIN  = 3'd1,
    REG_FLOOR = 3'd2,
    REG_INV_X = 3'd3,
    REG_INV_Y = 3'd4,
    REG_INV_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               func;
    logic [14:0]        moving_index;
    logic signed [15:0] intensity;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] new_disp_x;
    logic signed [23:0] new_disp_y;
    logic signed [23:0] new_disp_z;
    logic               inlier;
    logic               updated;
    logic [31:0]        diff_squared;
  } out_item_t;

endpackage

// ===== design/demons_displacement_update.sv =====
// Demons force update, one item per clock. busy_o never rises: a load or a
// process item may be started in every cycle. Results cannot be held off:
// done_o is a one-cycle strobe with no back-pressure. A process item gives
// its result on result_o with done_o high, and results leave in the order
// taken. Loads give none and take effect for any process item started on
// the next cycle or later. The three 25-stage restoring dividers (one
// quotient bit per stage) sit behind the store read; increments that would
// reach 2^25 are flagged before the divider and saturate. The moving stores
// are synchronous RAMs with no clearing pass: entries read before being
// loaded return whatever the RAM holds.
module demons_displacement_update import dmd_pkg::*; #(
  parameter int DIM_X = DimDef,
  parameter int DIM_Y = DimDef,
  parameter int DIM_Z = DimDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  in_item_t         in_i,
  output logic             busy_o,
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [CfgDW-1:0] cfg_wdata_i,
  output logic             done_o,
  output out_item_t        result_o
);

  localparam int Lat = QuoW + 9;
  localparam int Dims [3] = '{DIM_X, DIM_Y, DIM_Z};

  typedef struct packed {
    logic [DenW-1:0]            den;
    logic [2:0]                 neg;
    logic [2:0]                 ovf;
    logic [2:0][DenW-1:0]       rem;
    logic [2:0][QuoW-1:0]       nlo;
    logic [2:0][QuoW-1:0]       quo;
    logic [2:0][23:0]           disp;
    logic                       upd;
    logic                       inb;
    logic [31:0]                d2;
  } div_t;

  // configuration
  logic [15:0] homog_q, gain_q;
  logic [31:0] floor_q;
  logic [15:0] inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      homog_q  <= 16'hFFFF;
      gain_q   <= 16'd4096;
      floor_q  <= 32'd1;
      inv_q[0] <= 16'd4096;
      inv_q[1] <= 16'd4096;
      inv_q[2] <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_HOMOG: homog_q  <= cfg_wdata_i[15:0];
        REG_GAIN:  gain_q   <= cfg_wdata_i[15:0];
        REG_FLOOR: floor_q  <= cfg_wdata_i;
        REG_INV_X: inv_q[0] <= cfg_wdata_i[15:0];
        REG_INV_Y: inv_q[1] <= cfg_wdata_i[15:0];
        REG_INV_Z: inv_q[2] <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: gradient squares or coordinate products
  logic signed [23:0] vec_s [3];
  logic signed [15:0] g_s   [3];
  always_comb begin
    vec_s[0] = in_i.vec_x;
    vec_s[1] = in_i.vec_y;
    vec_s[2] = in_i.vec_z;
    for (int a = 0; a < 3; a++) g_s[a] = vec_s[a][15:0];
  end

  logic              v1_q;
  in_item_t          i1_q;
  logic [31:0]       sq1_q   [3];
  logic signed [40:0] prod1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] sq;
    i1_q <= in_i;
    for (int a = 0; a < 3; a++) begin
      sq          = g_s[a] * g_s[a];
      sq1_q[a]   <= sq;
      prod1_q[a] <= vec_s[a] * $signed({1'b0, inv_q[a]});
    end
  end

  // stage 2: round to a moving voxel, bounds check; magnitude for loads
  logic signed [23:0] pos1 [3];
  logic signed [23:0] dsp1 [3];
  logic signed [41:0] crd  [3];
  logic               inb_a [3];
  always_comb begin
    pos1[0] = i1_q.pos_x;  pos1[1] = i1_q.pos_y;  pos1[2] = i1_q.pos_z;
    dsp1[0] = i1_q.vec_x;  dsp1[1] = i1_q.vec_y;  dsp1[2] = i1_q.vec_z;
    for (int a = 0; a < 3; a++) begin
      // floor((c + 0.5)) matches half-away rounding wherever c > -0.5
      crd[a] = $signed({{6{pos1[a][23]}}, pos1[a], 12'b0})
             + $signed({prod1_q[a][40], prod1_q[a]}) + 42'sd524288;
      inb_a[a] = !crd[a][41] && (crd[a] != 42'sd0) && (crd[a][41:20] < 22'(Dims[a]));
    end
  end

  logic               v2_q, f2_q;
  logic [AddrW-1:0]   idx2_q;
  logic signed [15:0] int2_q;
  logic [47:0]        grad2_q;
  logic [31:0]        mag2_q;
  logic [PixW-1:0]    pix2_q  [3];
  logic               inb2_q;
  logic signed [23:0] disp2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    f2_q    <= i1_q.func;
    idx2_q  <= i1_q.moving_index;
    int2_q  <= i1_q.intensity;
    grad2_q <= {i1_q.vec_z[15:0], i1_q.vec_y[15:0], i1_q.vec_x[15:0]};
    mag2_q  <= sq1_q[0] + sq1_q[1] + sq1_q[2];
    inb2_q  <= inb_a[0] && inb_a[1] && inb_a[2];
    for (int a = 0; a < 3; a++) begin
      pix2_q[a]  <= crd[a][PixW+19:20];
      disp2_q[a] <= dsp1[a];
    end
  end

  // stage 3: store access, loads write, process items read
  logic [AddrW-1:0] ridx;
  assign ridx = AddrW'((AddrW'(pix2_q[2]) * AddrW'(DIM_Y) + AddrW'(pix2_q[1]))
                       * AddrW'(DIM_X) + AddrW'(pix2_q[0]));

  logic signed [15:0] mem_int  [Depth];
  logic [47:0]        mem_grad [Depth];
  logic [31:0]        mem_mag  [Depth];

  logic signed [15:0] mi3_q;
  logic [47:0]        mg3_q;
  logic [31:0]        mm3_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && f2_q == FuncLoad) begin
      mem_int[idx2_q]  <= int2_q;
      mem_grad[idx2_q] <= grad2_q;
      mem_mag[idx2_q]  <= mag2_q;
    end
    mi3_q <= mem_int[ridx];
    mg3_q <= mem_grad[ridx];
    mm3_q <= mem_mag[ridx];
  end

  logic               pv3_q, inb3_q;
  logic signed [15:0] fi3_q;
  logic signed [23:0] disp3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv3_q <= 1'b0;
    else         pv3_q <= v2_q && f2_q == FuncProc;
  end

  always_ff @(posedge clk_i) begin
    inb3_q  <= inb2_q;
    fi3_q   <= int2_q;
    disp3_q <= disp2_q;
  end

  // stage 4: difference and its square
  logic               pv4_q, inb4_q;
  logic signed [16:0] diff4_q;
  logic [31:0]        d2_4_q, mag4_q;
  logic [47:0]        grad4_q;
  logic signed [23:0] disp4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv4_q <= 1'b0;
    else         pv4_q <= pv3_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [16:0] df;
    logic signed [33:0] sq;
    df       = {fi3_q[15], fi3_q} - {mi3_q[15], mi3_q};
    sq       = df * df;
    diff4_q <= df;
    d2_4_q  <= sq[31:0];
    mag4_q  <= mm3_q;
    grad4_q <= mg3_q;
    inb4_q  <= inb3_q;
    disp4_q <= disp3_q;
  end

  // stage 5: weighted square, gain times difference
  logic               pv5_q, inb5_q;
  logic [47:0]        hp5_q, grad5_q;
  logic signed [33:0] sgd5_q;
  logic [31:0]        d2_5_q, mag5_q;
  logic signed [23:0] disp5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv5_q <= 1'b0;
    else         pv5_q <= pv4_q;
  end

  always_ff @(posedge clk_i) begin
    hp5_q   <= homog_q * d2_4_q;
    sgd5_q  <= $signed({1'b0, gain_q}) * diff4_q;
    d2_5_q  <= d2_4_q;
    mag5_q  <= mag4_q;
    grad5_q <= grad4_q;
    inb5_q  <= inb4_q;
    disp5_q <= disp4_q;
  end

  // stage 6: denominator and per-axis numerators
  logic               pv6_q, inb6_q;
  logic [DenW-1:0]    den6_q;
  logic signed [49:0] num6_q [3];
  logic [31:0]        d2_6_q;
  logic signed [23:0] disp6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv6_q <= 1'b0;
    else         pv6_q <= pv5_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [15:0] g;
    den6_q <= {17'b0, mag5_q} + {1'b0, hp5_q};
    for (int a = 0; a < 3; a++) begin
      g          = grad5_q[16*a +: 16];
      num6_q[a] <= sgd5_q * g;
    end
    d2_6_q  <= d2_5_q;
    inb6_q  <= inb5_q;
    disp6_q <= disp5_q;
  end

  // stage 7: floor test, rounded dividend magnitude
  logic               pv7_q, inb7_q, upd7_q;
  logic [NumW-1:0]    n7_q   [3];
  logic [2:0]         neg7_q;
  logic [DenW-1:0]    den7_q;
  logic [31:0]        d2_7_q;
  logic signed [23:0] disp7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv7_q <= 1'b0;
    else         pv7_q <= pv6_q;
  end

  always_ff @(posedge clk_i) begin
    logic [49:0] am;
    for (int a = 0; a < 3; a++) begin
      am         = num6_q[a][49] ? 50'(-num6_q[a]) : 50'(num6_q[a]);
      neg7_q[a] <= num6_q[a][49];
      n7_q[a]   <= {am, 4'b0} + NumW'(den6_q >> 1);
    end
    upd7_q  <= inb6_q && (den6_q != '0) && (den6_q >= DenW'(floor_q));
    den7_q  <= den6_q;
    d2_7_q  <= d2_6_q;
    inb7_q  <= inb6_q;
    disp7_q <= disp6_q;
  end

  // stage 8 and divider: quotient bits MSB first, one per stage
  div_t dv_q  [QuoW+1];
  logic dvld_q [QuoW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dvld_q[0] <= 1'b0;
    else         dvld_q[0] <= pv7_q;
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].den <= den7_q;
    dv_q[0].neg <= neg7_q;
    dv_q[0].upd <= upd7_q;
    dv_q[0].inb <= inb7_q;
    dv_q[0].d2  <= d2_7_q;
    for (int a = 0; a < 3; a++) begin
      dv_q[0].ovf[a]  <= {20'b0, n7_q[a]} >= {den7_q, 25'b0};
      dv_q[0].rem[a]  <= DenW'(n7_q[a][NumW-1:QuoW]);
      dv_q[0].nlo[a]  <= n7_q[a][QuoW-1:0];
      dv_q[0].quo[a]  <= '0;
      dv_q[0].disp[a] <= disp7_q[a];
    end
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    div_t nxt;
    always_comb begin
      logic [DenW:0] rs;
      nxt = dv_q[j];
      for (int a = 0; a < 3; a++) begin
        rs = {dv_q[j].rem[a], dv_q[j].nlo[a][QuoW-1]};
        if (rs >= {1'b0, dv_q[j].den}) begin
          rs = rs - {1'b0, dv_q[j].den};
          nxt.quo[a] = {dv_q[j].quo[a][QuoW-2:0], 1'b1};
        end else begin
          nxt.quo[a] = {dv_q[j].quo[a][QuoW-2:0], 1'b0};
        end
        nxt.rem[a] = rs[DenW-1:0];
        nxt.nlo[a] = {dv_q[j].nlo[a][QuoW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvld_q[j+1] <= 1'b0;
      else         dvld_q[j+1] <= dvld_q[j];
    end

    always_ff @(posedge clk_i) begin
      dv_q[j+1] <= nxt;
    end
  end

  // output: sign, saturating add
  logic signed [23:0] nd [3];
  always_comb begin
    logic [QuoW:0]      incm;
    logic signed [27:0] inc, sum;
    for (int a = 0; a < 3; a++) begin
      incm = dv_q[QuoW].ovf[a] ? {1'b1, {QuoW{1'b0}}} : {1'b0, dv_q[QuoW].quo[a]};
      inc  = dv_q[QuoW].neg[a] ? -$signed({2'b0, incm}) : $signed({2'b0, incm});
      sum  = $signed({{4{dv_q[QuoW].disp[a][23]}}, dv_q[QuoW].disp[a]}) + inc;
      if (!dv_q[QuoW].upd)           nd[a] = dv_q[QuoW].disp[a];
      else if (sum > 28'sd8388607)   nd[a] = 24'sh7FFFFF;
      else if (sum < -28'sd8388608)  nd[a] = 24'sh800000;
      else                           nd[a] = sum[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= dvld_q[QuoW];
  end

  always_ff @(posedge clk_i) begin
    result_o.new_disp_x   <= nd[0];
    result_o.new_disp_y   <= nd[1];
    result_o.new_disp_z   <= nd[2];
    result_o.inlier       <= dv_q[QuoW].inb;
    result_o.updated      <= dv_q[QuoW].upd;
    result_o.diff_squared <= dv_q[QuoW].inb ? dv_q[QuoW].d2 : 32'd0;
  end

`ifndef ASSERT_OFF
  a_done_from_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && in_i.func == FuncProc, Lat))
    else $error("result without a process item");

  a_upd_inlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.updated |-> result_o.inlier)
    else $error("update on an outlier");

  a_outlier_d2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.inlier |-> result_o.diff_squared == 32'd0)
    else $error("outlier with nonzero diff_squared");

  a_keep_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.updated |-> result_o.new_disp_x == $past(in_i.vec_x, Lat))
    else $error("displacement changed without update");
`endif

endmodule
